FILE: hdl/hkvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed key-value table package
// Operation codes, hash constants, status types and the string helpers that
// the slot unit, the store and the top level use.
// ----------------------------------------------------------------------------
package hkvt_pkg;

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  localparam logic [31:0] HASH_SEED    = 32'd5381;
  localparam int          HASH_SHIFT   = 5;
  localparam int          SLOT_FIELD_W = 10;

  typedef struct packed {
    logic clearing;
    logic done;
  } store_status_t;

  // Keeps the bytes before the first zero byte, at most limit of them.
  function automatic logic [63:0] normalize(input logic [63:0] raw, input int limit);
    logic [63:0] result;
    logic        stop;
    result = '0;
    stop   = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= limit || raw[8*i +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        result[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return result;
  endfunction

  // djb2 over the bytes before the first zero byte, modulo 2^32.
  function automatic logic [31:0] djb2(input logic [63:0] key);
    logic [31:0] h;
    logic        stop;
    h    = HASH_SEED;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (key[8*i +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        h = (h << HASH_SHIFT) + h + {24'd0, key[8*i +: 8]};
      end
    end
    return h;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/hkvt_slot.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed key-value table slot unit
// Hashes a normalized key and reduces the hash modulo the table size. A
// power-of-two table takes the low bits; any other size uses a reciprocal
// multiply, a back multiply and one corrective subtract over three stages.
// ----------------------------------------------------------------------------
module hkvt_slot
  import hkvt_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024,
  parameter int SLOT_W      = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [63:0]       key,
  output logic                   slot_done,
  output logic [SLOT_W-1:0]      slot
);

  localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

  logic [31:0] hash;
  logic        hash_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_v <= 1'b0;
    end else begin
      hash_v <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hash <= djb2(key);
    end
  end

  generate
    if (IS_POW2) begin : g_pow2
      assign slot_done = hash_v;
      assign slot      = hash[SLOT_W-1:0];
    end else begin : g_recip
      // The truncated reciprocal leaves the quotient at most one low, so the
      // remainder lies below twice the divisor.
      localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / TABLE_SLOTS);
      localparam logic [31:0] DIVISOR = 32'(TABLE_SLOTS);

      logic        quot_v;
      logic        back_v;
      logic [31:0] quot_est;
      logic [31:0] hash_q;
      logic [31:0] back_prod;
      logic [31:0] hash_b;
      logic [63:0] recip_prod;
      logic [31:0] rem;
      logic [31:0] rem_fixed;

      assign recip_prod = {32'd0, hash} * {32'd0, RECIP};

      always_ff @(posedge clk) begin
        if (rst) begin
          quot_v <= 1'b0;
          back_v <= 1'b0;
        end else begin
          quot_v <= hash_v;
          back_v <= quot_v;
        end
      end

      always_ff @(posedge clk) begin
        quot_est  <= recip_prod[63:32];
        hash_q    <= hash;
        back_prod <= quot_est * DIVISOR;
        hash_b    <= hash_q;
      end

      assign rem       = hash_b - back_prod;
      assign rem_fixed = (rem >= DIVISOR) ? rem - DIVISOR : rem;
      assign slot_done = back_v;
      assign slot      = rem_fixed[SLOT_W-1:0];
    end
  endgenerate

endmodule
`default_nettype wire

FILE: hdl/hkvt_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed key-value table store
// Holds the key memory (with the valid mark) and the value memory. Reads a
// slot, compares the stored key on the next cycle and writes back. After
// reset it sweeps the key memory to clear every valid mark.
// ----------------------------------------------------------------------------
module hkvt_store
  import hkvt_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024,
  parameter int SLOT_W      = 10,
  parameter int KEY_W       = 64,
  parameter int VAL_W       = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd,
  input  wire logic [SLOT_W-1:0] rd_addr,
  input  wire logic [1:0]        op,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [VAL_W-1:0]  value,
  output store_status_t          status,
  output logic                   found,
  output logic [VAL_W-1:0]       value_out,
  output logic [SLOT_W-1:0]      slot
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  // Each key entry carries its valid mark in the top bit.
  logic [KEY_W:0]      key_mem   [TABLE_SLOTS];
  logic [VAL_W-1:0]    value_mem [TABLE_SLOTS];

  logic                clearing;
  logic [SLOT_W-1:0]   clr_addr;
  logic                cmp_v;
  logic [SLOT_W-1:0]   cmp_slot;
  logic [KEY_W:0]      rd_key_ent;
  logic [VAL_W-1:0]    rd_val;
  logic                hit;
  logic                key_wr;
  logic                val_wr;
  logic [SLOT_W-1:0]   wr_addr;
  logic [KEY_W:0]      wr_key_ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      cmp_v    <= 1'b0;
    end else begin
      cmp_v <= rd;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_SLOT) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      cmp_slot <= rd_addr;
    end
  end

  assign hit = rd_key_ent[KEY_W] && (rd_key_ent[KEY_W-1:0] == key);

  always_comb begin
    key_wr     = 1'b0;
    val_wr     = 1'b0;
    wr_addr    = cmp_slot;
    wr_key_ent = {1'b1, key};
    if (clearing) begin
      key_wr     = 1'b1;
      wr_addr    = clr_addr;
      wr_key_ent = '0;
    end else if (cmp_v) begin
      case (op)
        OP_SET: begin
          key_wr = 1'b1;
          val_wr = 1'b1;
        end
        OP_DEL: begin
          key_wr     = hit;
          wr_key_ent = {1'b0, key};
        end
        default: begin
          key_wr = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[wr_addr] <= wr_key_ent;
    end
    if (val_wr) begin
      value_mem[wr_addr] <= value;
    end
    if (rd) begin
      rd_key_ent <= key_mem[rd_addr];
      rd_val     <= value_mem[rd_addr];
    end
  end

  assign status.clearing = clearing;
  assign status.done     = cmp_v;
  assign found           = hit && (op == OP_GET || op == OP_DEL);
  assign value_out       = (hit && op == OP_GET) ? rd_val : '0;
  assign slot            = cmp_slot;

endmodule
`default_nettype wire

FILE: hdl/hashed_key_value_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Path to done: the hash register, the memory read, the compare/write-back and the
// done register; other table sizes add two multiply stages for the modulo reduction.
// A new transaction is taken only after busy falls; busy covers the hash,
// slot reduction, the memory read and the compare/write-back.
// Reset clears the valid marks with a sweep over every slot, during
// which busy is high. The receiver cannot stall; done is high for one cycle per result.
// ----------------------------------------------------------------------------
// Hashed key-value table core
// Direct-mapped store of zero-terminated keys and values, set/get/delete,
// slot chosen by a djb2 hash modulo the table size.
// ----------------------------------------------------------------------------
module hashed_key_value_table_core
  import hkvt_pkg::*;
#(
  parameter int TABLE_SLOTS = 1024,
  parameter int KEY_CHARS   = 8,
  parameter int VALUE_CHARS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [63:0] key_bytes,
  input  wire logic [63:0] value_bytes,
  output logic             done,
  output logic             found,
  output logic [63:0]      value_out,
  output logic [9:0]       slot_index
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int KEY_W  = 8 * KEY_CHARS;
  localparam int VAL_W  = 8 * VALUE_CHARS;

  logic              accept;
  logic              item_active;
  logic [63:0]       key_norm;
  logic [63:0]       val_norm;
  logic [1:0]        op_reg;
  logic [KEY_W-1:0]  key_reg;
  logic [VAL_W-1:0]  val_reg;
  logic              slot_done;
  logic [SLOT_W-1:0] slot;
  store_status_t     status;
  logic              st_found;
  logic [VAL_W-1:0]  st_value;
  logic [SLOT_W-1:0] st_slot;
  logic [31:0]       slot_wide;

  assign key_norm = normalize(key_bytes, KEY_CHARS);
  assign val_norm = normalize(value_bytes, VALUE_CHARS);
  assign busy     = item_active | status.clearing;
  assign accept   = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_active <= 1'b0;
    end else if (accept) begin
      item_active <= 1'b1;
    end else if (status.done) begin
      item_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg  <= op;
      key_reg <= key_norm[KEY_W-1:0];
      val_reg <= val_norm[VAL_W-1:0];
    end
  end

  hkvt_slot #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_slot (
    .clk       (clk),
    .rst       (rst),
    .go        (accept),
    .key       (key_norm),
    .slot_done (slot_done),
    .slot      (slot)
  );

  hkvt_store #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W),
    .KEY_W       (KEY_W),
    .VAL_W       (VAL_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd        (slot_done),
    .rd_addr   (slot),
    .op        (op_reg),
    .key       (key_reg),
    .value     (val_reg),
    .status    (status),
    .found     (st_found),
    .value_out (st_value),
    .slot      (st_slot)
  );

  // The reported slot is the table slot masked to the ten-bit result field.
  assign slot_wide = 32'(st_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= status.done;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      found      <= st_found;
      value_out  <= 64'(st_value);
      slot_index <= slot_wide[SLOT_FIELD_W-1:0];
    end
  end

endmodule
`default_nettype wire
